/* rtl/core/vrpt_pkg.sv */
package vrpt_pkg;

  // block sizing
  localparam int unsigned NAME_RAM_BYTES  = 2048;
  localparam int unsigned SPRITE_COUNT    = 64;
  localparam int unsigned DOTS_PER_LINE   = 341;
  localparam int unsigned LINES_PER_FRAME = 262;
  localparam int unsigned VBLANK_LINE     = 240;

  localparam int unsigned SPR_BYTES = SPRITE_COUNT * 4;
  localparam int unsigned SPR_AW    = $clog2(SPR_BYTES);
  localparam int unsigned NR_AW     = $clog2(NAME_RAM_BYTES);
  localparam int unsigned BEAM_W    = 9;
  localparam int unsigned PAL_AW    = 5;
  localparam int unsigned PAL_BYTES = 32;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // ctrl bits
  localparam int unsigned CTRL_INC_BIT = 2;
  localparam int unsigned CTRL_NMI_BIT = 7;

  // video memory map
  localparam logic [15:0] CART_TOP     = 16'h2000;
  localparam logic [15:0] PAL_BASE     = 16'h3f00;
  localparam logic [PAL_AW-1:0] PAL_MIRROR = 5'h10;
  localparam logic [15:0] INC_ROW      = 16'd32;
  localparam logic [15:0] INC_ONE      = 16'd1;

  // sprite zero bytes kept in shadow registers
  localparam logic [SPR_AW-1:0] SPR_Y_IDX = SPR_AW'(0);
  localparam logic [SPR_AW-1:0] SPR_X_IDX = SPR_AW'(3);

  // per-tick events from the beam counter
  typedef struct packed {
    logic scanline;
    logic vbl_start;
    logic frame_end;
    logic spr_hit;
  } vrpt_beam_evt_t;

  // remainder by a constant for quotients below 16: binary long division
  function automatic logic [15:0] const_mod16(input logic [15:0] value,
                                              input int unsigned modulus);
    logic [31:0] v;
    logic [31:0] m;
    v = {16'd0, value};
    for (int k = 3; k >= 0; k--) begin
      m = 32'(modulus) << k;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[15:0];
  endfunction

  // palette entry, 0x10 folds onto entry 0
  function automatic logic [PAL_AW-1:0] pal_index(input logic [15:0] addr);
    logic [15:0] off;
    off = addr - PAL_BASE;
    return (off[PAL_AW-1:0] == PAL_MIRROR) ? '0 : off[PAL_AW-1:0];
  endfunction

endpackage

/* rtl/core/vrpt_ram.sv */
module vrpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/vrpt_beam.sv */
module vrpt_beam (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    tick,
  input  logic [7:0]              spr_y,
  input  logic [7:0]              spr_x,
  output vrpt_pkg::vrpt_beam_evt_t evt
);
  import vrpt_pkg::*;

  localparam logic [BEAM_W-1:0] DOTS    = BEAM_W'(DOTS_PER_LINE);
  localparam logic [BEAM_W-1:0] LINES   = BEAM_W'(LINES_PER_FRAME);
  localparam logic [BEAM_W-1:0] VBL     = BEAM_W'(VBLANK_LINE);
  localparam logic [BEAM_W-1:0] LAST_LN = BEAM_W'(LINES_PER_FRAME - 1);
  localparam logic [BEAM_W-1:0] DOT_ONE = BEAM_W'(1);

  logic [BEAM_W-1:0] dot_r, dot_nxt;
  logic [BEAM_W-1:0] line_r, line_nxt;

  // next beam position
  always_comb begin
    dot_nxt  = dot_r + BEAM_W'(1);
    line_nxt = line_r;
    if (dot_nxt >= DOTS) begin
      dot_nxt  = '0;
      line_nxt = line_r + BEAM_W'(1);
    end
    if (line_nxt >= LINES) begin
      line_nxt = '0;
      dot_nxt  = '0;
    end
  end

  // events seen at the new position
  always_comb begin
    evt.spr_hit   = (line_nxt == BEAM_W'(spr_y)) && (dot_nxt == BEAM_W'(spr_x));
    evt.scanline  = (dot_nxt == '0) && (line_nxt <= VBL);
    evt.vbl_start = (line_nxt == VBL) && (dot_nxt == DOT_ONE);
    evt.frame_end = !evt.vbl_start && (line_nxt == LAST_LN) && (dot_nxt == DOT_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r  <= '0;
      line_r <= '0;
    end else if (tick) begin
      dot_r  <= dot_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

/* rtl/core/video_register_port_and_timing.sv */
// channel  dir  handshake              payload
// in_      in   in_valid / in_stall    req_type, reg_sel, wdata, cart_data
// out_     out  out_valid / out_stall  rdata, vram_addr, cart_write, cart_wdata,
//                                      nmi_pulse, vblank_start, scanline_pulse
//
// One beat per cycle sustained while out_stall is low and no clear pass runs; a beat
// is decoded and updates state at the edge that accepts it, the name and sprite
// RAM reads land in the result stage at that same edge, then an output register:
// out_valid rises when the result stage moves into the output register.
// After reset the name RAM is cleared one byte a cycle, all NAME_RAM_BYTES bytes
// (2048), with in_stall high.
// A stall on out_ fills the output register and then the result stage; in_stall
// rises only when both are full or while the name RAM clear runs.
module video_register_port_and_timing (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_reg_sel,
  input  logic [7:0]  in_wdata,
  input  logic [7:0]  in_cart_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_rdata,
  output logic [15:0] out_vram_addr,
  output logic        out_cart_write,
  output logic [7:0]  out_cart_wdata,
  output logic        out_nmi_pulse,
  output logic        out_vblank_start,
  output logic        out_scanline_pulse
);
  import vrpt_pkg::*;

  // architectural state
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic              vbl_r, vbl_nxt;
  logic              szf_r, szf_nxt;
  logic [4:0]        lwl_r, lwl_nxt;
  logic [7:0]        ptr_r, ptr_nxt;
  logic              tog_r, tog_nxt;
  logic [15:0]       va_r, va_nxt;
  logic [7:0]        rb_r, rb_nxt;
  logic [7:0]        spr_y_r, spr_x_r;
  logic [SPR_BYTES-1:0] spr_vld_r;
  logic [7:0]        pal_r [PAL_BYTES];

  // name ram clearing pass
  logic              clr_busy_r;
  logic [NR_AW-1:0]  clr_cnt_r;

  // result stage
  logic              s_valid_r;
  logic [7:0]        s_rdata_r;
  logic              s_rd_spr_r;
  logic              s_spr_vld_r;
  logic              s_dread_r;
  logic              s_rb_ram_r;
  logic [7:0]        s_rb_fix_r;
  logic [15:0]       s_vaddr_r;
  logic              s_cwr_r;
  logic [7:0]        s_cwd_r;
  logic              s_nmi_r;
  logic              s_vbs_r;
  logic              s_scl_r;

  // output register
  logic              o_valid_r;
  logic [7:0]        o_rdata_r;
  logic [15:0]       o_vaddr_r;
  logic              o_cwr_r;
  logic [7:0]        o_cwd_r;
  logic              o_nmi_r;
  logic              o_vbs_r;
  logic              o_scl_r;

  logic              accept;
  logic              s_adv;
  logic              o_take;

  logic [15:0]       addr_inc;
  logic [15:0]       nr_off;
  logic [15:0]       nr_mod;
  logic [NR_AW-1:0]  nidx;
  logic [15:0]       spr_mod;
  logic [SPR_AW-1:0] sidx;
  logic [PAL_AW-1:0] pidx;
  logic              va_cart;
  logic              va_name;

  logic [7:0]        nr_q;
  logic [7:0]        spr_q;
  logic              nr_we;
  logic [NR_AW-1:0]  nr_waddr;
  logic [7:0]        nr_wdata;

  vrpt_beam_evt_t    evt;
  logic              beam_tick;

  logic [7:0]        c_rdata;
  logic              c_rd_spr;
  logic              c_dread;
  logic              c_rb_ram;
  logic [7:0]        c_rb_fix;
  logic              c_data;
  logic              c_cwr;
  logic [7:0]        c_cwd;
  logic              c_nmi;
  logic              c_vbs;
  logic              c_scl;
  logic              spr_we;
  logic              nr_acc_we;
  logic              pal_we;

  logic [7:0]        s_rdata_fin;
  logic [7:0]        s_rb_new;
  logic [7:0]        rb_eff;

  // handshake
  assign o_take   = o_valid_r && !out_stall;
  assign s_adv    = s_valid_r && (!o_valid_r || !out_stall);
  assign in_stall = clr_busy_r || (s_valid_r && o_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // address decode
  assign addr_inc = ctrl_r[CTRL_INC_BIT] ? INC_ROW : INC_ONE;
  assign va_cart  = va_r < CART_TOP;
  assign va_name  = !va_cart && (va_r < PAL_BASE);
  assign nr_off   = va_r - CART_TOP;
  assign nr_mod   = const_mod16(nr_off, NAME_RAM_BYTES);
  assign nidx     = nr_mod[NR_AW-1:0];
  assign spr_mod  = const_mod16({8'd0, ptr_r}, SPR_BYTES);
  assign sidx     = spr_mod[SPR_AW-1:0];
  assign pidx     = pal_index(va_r);

  // read buffer as seen by the beat being accepted
  assign s_rb_new = s_rb_ram_r ? nr_q : s_rb_fix_r;
  assign rb_eff   = (s_valid_r && s_dread_r) ? s_rb_new : rb_r;
  assign rb_nxt   = rb_eff;

  vrpt_beam u_beam (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (accept && beam_tick),
    .spr_y (spr_y_r),
    .spr_x (spr_x_r),
    .evt   (evt)
  );

  // request decode and state update
  always_comb begin
    ctrl_nxt  = ctrl_r;
    vbl_nxt   = vbl_r;
    szf_nxt   = szf_r;
    lwl_nxt   = lwl_r;
    ptr_nxt   = ptr_r;
    tog_nxt   = tog_r;
    va_nxt    = va_r;
    c_rdata   = '0;
    c_rd_spr  = 1'b0;
    c_dread   = 1'b0;
    c_rb_ram  = 1'b0;
    c_rb_fix  = '0;
    c_data    = 1'b0;
    c_cwr     = 1'b0;
    c_cwd     = '0;
    c_nmi     = 1'b0;
    c_vbs     = 1'b0;
    c_scl     = 1'b0;
    spr_we    = 1'b0;
    nr_acc_we = 1'b0;
    pal_we    = 1'b0;
    beam_tick = 1'b0;
    case (in_req_type)
      REQ_TICK: begin
        beam_tick = 1'b1;
        c_scl     = evt.scanline;
        if (evt.spr_hit) begin
          szf_nxt = 1'b1;
        end
        if (evt.vbl_start) begin
          vbl_nxt = 1'b1;
          c_vbs   = 1'b1;
          c_nmi   = ctrl_r[CTRL_NMI_BIT];
        end else if (evt.frame_end) begin
          vbl_nxt = 1'b0;
          szf_nxt = 1'b0;
        end
      end
      REQ_READ: begin
        case (in_reg_sel)
          REG_STATUS: begin
            c_rdata = {vbl_r, szf_r, 1'b0, lwl_r};
            tog_nxt = 1'b0;
            vbl_nxt = 1'b0;
          end
          REG_OAM_DATA: begin
            c_rd_spr = 1'b1;
          end
          REG_DATA: begin
            c_data  = 1'b1;
            c_dread = 1'b1;
            c_rdata = rb_eff;
            if (va_cart) begin
              c_rb_fix = in_cart_data;
            end else if (va_name) begin
              c_rb_ram = 1'b1;
            end else begin
              c_rb_fix = pal_r[pidx];
            end
            va_nxt = va_r + addr_inc;
          end
          default: begin
          end
        endcase
      end
      REQ_WRITE: begin
        lwl_nxt = in_wdata[4:0];
        case (in_reg_sel)
          REG_CTRL: begin
            ctrl_nxt = in_wdata;
          end
          // the mask byte has no consumer in this block
          REG_MASK: begin
          end
          REG_OAM_ADDR: begin
            ptr_nxt = in_wdata;
          end
          REG_OAM_DATA: begin
            spr_we  = 1'b1;
            ptr_nxt = ptr_r + 8'd1;
          end
          REG_SCROLL: begin
            tog_nxt = !tog_r;
          end
          REG_ADDR: begin
            if (!tog_r) begin
              va_nxt = {in_wdata, va_r[7:0]};
            end else begin
              va_nxt = {va_r[15:8], in_wdata};
            end
            tog_nxt = !tog_r;
          end
          REG_DATA: begin
            c_data = 1'b1;
            if (va_cart) begin
              c_cwr = 1'b1;
              c_cwd = in_wdata;
            end else if (va_name) begin
              nr_acc_we = 1'b1;
            end else begin
              pal_we = 1'b1;
            end
            va_nxt = va_r + addr_inc;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // register state on an accepted beat; rb_r loads without waiting for accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      vbl_r   <= 1'b0;
      szf_r   <= 1'b0;
      lwl_r   <= '0;
      ptr_r   <= '0;
      tog_r   <= 1'b0;
      va_r    <= '0;
      rb_r    <= '0;
    end else begin
      rb_r <= rb_nxt;
      if (accept) begin
        ctrl_r <= ctrl_nxt;
        vbl_r  <= vbl_nxt;
        szf_r  <= szf_nxt;
        lwl_r  <= lwl_nxt;
        ptr_r  <= ptr_nxt;
        tog_r  <= tog_nxt;
        va_r   <= va_nxt;
      end
    end
  end

  // palette, sprite zero shadow and sprite valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAL_BYTES; i++) begin
        pal_r[i] <= '0;
      end
      spr_y_r   <= '0;
      spr_x_r   <= '0;
      spr_vld_r <= '0;
    end else if (accept) begin
      if (pal_we) begin
        pal_r[pidx] <= in_wdata;
      end
      if (spr_we) begin
        spr_vld_r[sidx] <= 1'b1;
        if (sidx == SPR_Y_IDX) begin
          spr_y_r <= in_wdata;
        end
        if (sidx == SPR_X_IDX) begin
          spr_x_r <= in_wdata;
        end
      end
    end
  end

  // name ram clear after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + NR_AW'(1);
      if (clr_cnt_r == NR_AW'(NAME_RAM_BYTES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign nr_we    = clr_busy_r || (accept && nr_acc_we);
  assign nr_waddr = clr_busy_r ? clr_cnt_r : nidx;
  assign nr_wdata = clr_busy_r ? 8'd0 : in_wdata;

  vrpt_ram #(
    .WIDTH (8),
    .DEPTH (NAME_RAM_BYTES)
  ) u_name_ram (
    .clk   (clk),
    .we    (nr_we),
    .waddr (nr_waddr),
    .wdata (nr_wdata),
    .re    (accept),
    .raddr (nidx),
    .rdata (nr_q)
  );

  vrpt_ram #(
    .WIDTH (8),
    .DEPTH (SPR_BYTES)
  ) u_spr_ram (
    .clk   (clk),
    .we    (accept && spr_we),
    .waddr (sidx),
    .wdata (in_wdata),
    .re    (accept),
    .raddr (sidx),
    .rdata (spr_q)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (accept) begin
      s_valid_r <= 1'b1;
    end else if (s_adv) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_rdata_r   <= c_rdata;
      s_rd_spr_r  <= c_rd_spr;
      s_spr_vld_r <= spr_vld_r[sidx];
      s_dread_r   <= c_dread;
      s_rb_ram_r  <= c_rb_ram;
      s_rb_fix_r  <= c_rb_fix;
      s_vaddr_r   <= c_data ? va_r : va_nxt;
      s_cwr_r     <= c_cwr;
      s_cwd_r     <= c_cwd;
      s_nmi_r     <= c_nmi;
      s_vbs_r     <= c_vbs;
      s_scl_r     <= c_scl;
    end
  end

  // sprite bytes never written read as zero
  assign s_rdata_fin = s_rd_spr_r ? (s_spr_vld_r ? spr_q : 8'd0) : s_rdata_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s_adv) begin
      o_valid_r <= 1'b1;
    end else if (o_take) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) begin
      o_rdata_r <= s_rdata_fin;
      o_vaddr_r <= s_vaddr_r;
      o_cwr_r   <= s_cwr_r;
      o_cwd_r   <= s_cwd_r;
      o_nmi_r   <= s_nmi_r;
      o_vbs_r   <= s_vbs_r;
      o_scl_r   <= s_scl_r;
    end
  end

  assign out_valid          = o_valid_r;
  assign out_rdata          = o_rdata_r;
  assign out_vram_addr      = o_vaddr_r;
  assign out_cart_write     = o_cwr_r;
  assign out_cart_wdata     = o_cwd_r;
  assign out_nmi_pulse      = o_nmi_r;
  assign out_vblank_start   = o_vbs_r;
  assign out_scanline_pulse = o_scl_r;

endmodule

/* rtl/core/vrpt_checker.sv */
module vrpt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_rdata,
  input logic [15:0] out_vram_addr,
  input logic        out_cart_write,
  input logic [7:0]  out_cart_wdata,
  input logic        out_nmi_pulse,
  input logic        out_vblank_start,
  input logic        out_scanline_pulse
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rdata) && $stable(out_vram_addr))
    else $error("result beat changed under stall");

  // cartridge byte only travels with a cartridge write
  a_cart_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cart_write |-> out_cart_wdata == 8'd0)
    else $error("cartridge data without cartridge write");

  // nmi only at the start of vblank
  a_nmi_vbl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nmi_pulse |-> out_vblank_start)
    else $error("nmi outside vblank start");

  // beam events come from ticks only
  a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_vblank_start || out_scanline_pulse)
      |-> !out_cart_write && out_rdata == 8'd0)
    else $error("beam event on a register access");

endmodule

bind video_register_port_and_timing vrpt_checker u_vrpt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_rdata          (out_rdata),
  .out_vram_addr      (out_vram_addr),
  .out_cart_write     (out_cart_write),
  .out_cart_wdata     (out_cart_wdata),
  .out_nmi_pulse      (out_nmi_pulse),
  .out_vblank_start   (out_vblank_start),
  .out_scanline_pulse (out_scanline_pulse)
);
